>>> sv/guidance_mode_selector_assert.svh
// Assertion macros for the guidance mode selector.
// Used by the top level; relies on signals clk and rst_n in the including scope.
`ifndef GUIDANCE_MODE_SELECTOR_ASSERT_SVH
`define GUIDANCE_MODE_SELECTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GMS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("guidance mode selector: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define GMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("guidance mode selector: next-cycle check failed");

`endif

>>> sv/gms_pkg.sv
// Shared types, codes and constants of the guidance mode selector.
// No dependencies; imported by every module of the block.
package gms_pkg;

  localparam int COUNT_CAP_DEF = 50;

  localparam int TIMEOUT_W  = 16;
  localparam int THRESH_W   = 8;
  localparam int AGE_W      = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  localparam logic [TIMEOUT_W-1:0] WP_TIMEOUT_RST  = 16'd400;
  localparam logic [TIMEOUT_W-1:0] VIS_TIMEOUT_RST = 16'd200;
  localparam logic [THRESH_W-1:0]  WP_GOOD_RST     = 8'd5;
  localparam logic [THRESH_W-1:0]  WP_LOST_RST     = 8'd3;
  localparam logic [THRESH_W-1:0]  VIS_GOOD_RST    = 8'd3;
  localparam logic [THRESH_W-1:0]  VIS_LOST_RST    = 8'd3;

  typedef enum logic [1:0] {
    MODE_STOP     = 2'd0,
    MODE_WAYPOINT = 2'd1,
    MODE_VISION   = 2'd2,
    MODE_EMERG    = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    RSN_NONE             = 4'd0,
    RSN_STALE            = 4'd1,
    RSN_LDR_ESTOP        = 4'd2,
    RSN_LDR_FAULT        = 4'd3,
    RSN_WP_TIMEOUT       = 4'd4,
    RSN_VISION_TIMEOUT   = 4'd5,
    RSN_WP_RECOVERED     = 4'd6,
    RSN_VISION_RECOVERED = 4'd7,
    RSN_BOTH_LOST        = 4'd8,
    RSN_INIT             = 4'd9
  } reason_t;

  typedef enum logic [1:0] {
    LDR_NORMAL = 2'd0,
    LDR_ESTOP  = 2'd1,
    LDR_FAULT  = 2'd2
  } leader_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_WP_TIMEOUT  = 3'd0,
    CFG_VIS_TIMEOUT = 3'd1,
    CFG_WP_GOOD     = 3'd2,
    CFG_WP_LOST     = 3'd3,
    CFG_VIS_GOOD    = 3'd4,
    CFG_VIS_LOST    = 3'd5,
    CFG_LATCH_EN    = 3'd6
  } cfg_idx_t;

  // Source health after this tick's count update.
  typedef struct packed {
    logic good;
    logic bad;
  } src_status_t;

  // Outcome of one decision tick.
  typedef struct packed {
    mode_t   mode;
    reason_t reason;
    logic    latch_set;
    logic    count_en;
  } decision_t;

  typedef struct packed {
    reason_t reason;
    mode_t   mode;
  } result_t;

endpackage

>>> sv/gms_source_track.sv
// Freshness check and saturating good/lost counters for one guidance source.
// Depends on gms_pkg.
module gms_source_track import gms_pkg::*; #(
  parameter int COUNT_CAP = COUNT_CAP_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 upd,
  input  logic                 src_valid,
  input  logic [AGE_W-1:0]     src_age,
  input  logic [TIMEOUT_W-1:0] timeout,
  input  logic [THRESH_W-1:0]  good_thr,
  input  logic [THRESH_W-1:0]  lost_thr,
  output src_status_t          status
);

  localparam int CNT_W = $clog2(COUNT_CAP + 1);
  localparam int CMP_W = (CNT_W > THRESH_W) ? CNT_W : THRESH_W;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(COUNT_CAP);
  localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

  logic [CNT_W-1:0] good_r, good_nxt;
  logic [CNT_W-1:0] lost_r, lost_nxt;
  logic             fresh;

  assign fresh = src_valid && (src_age <= timeout);

  // Counts as they would stand after an update; status is only used then.
  always_comb begin
    if (fresh) begin
      good_nxt = (good_r < CAP) ? good_r + ONE : CAP;
      lost_nxt = (lost_r != '0) ? lost_r - ONE : '0;
    end else begin
      lost_nxt = (lost_r < CAP) ? lost_r + ONE : CAP;
      good_nxt = (good_r != '0) ? good_r - ONE : '0;
    end
  end

  assign status.good = CMP_W'(good_nxt) >= CMP_W'(good_thr);
  assign status.bad  = CMP_W'(lost_nxt) >= CMP_W'(lost_thr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      good_r <= '0;
      lost_r <= '0;
    end else if (upd) begin
      good_r <= good_nxt;
      lost_r <= lost_nxt;
    end
  end

endmodule

>>> sv/gms_mode_decide.sv
// Mode transition logic: leader safety, source-driven transitions, final guard.
// Depends on gms_pkg; purely combinational.
module gms_mode_decide import gms_pkg::*; (
  input  mode_t       mode_r,
  input  logic        started_r,
  input  logic        latched_r,
  input  logic        latch_en,
  input  logic [1:0]  leader_status,
  input  src_status_t wp,
  input  src_status_t vis,
  output decision_t   dec
);

  mode_t   mode;
  reason_t reason;

  always_comb begin
    mode          = started_r ? mode_r : MODE_STOP;
    reason        = started_r ? RSN_NONE : RSN_INIT;
    dec.latch_set = 1'b0;
    dec.count_en  = 1'b0;

    case (leader_status)
      LDR_ESTOP: begin
        dec.latch_set = latch_en;
        mode          = MODE_EMERG;
        reason        = RSN_LDR_ESTOP;
      end
      LDR_FAULT: begin
        mode   = MODE_STOP;
        reason = RSN_LDR_FAULT;
      end
      default: begin
        if (latched_r) begin
          mode   = MODE_EMERG;
          reason = RSN_LDR_ESTOP;
        end else begin
          dec.count_en = 1'b1;
          case (mode)
            MODE_WAYPOINT: begin
              if (wp.bad) begin
                if (vis.good) begin
                  mode   = MODE_VISION;
                  reason = RSN_WP_TIMEOUT;
                end else begin
                  mode   = MODE_STOP;
                  reason = RSN_BOTH_LOST;
                end
              end
            end
            MODE_VISION: begin
              if (wp.good) begin
                mode   = MODE_WAYPOINT;
                reason = RSN_WP_RECOVERED;
              end else if (vis.bad) begin
                mode   = MODE_STOP;
                reason = RSN_VISION_TIMEOUT;
              end
            end
            MODE_STOP: begin
              if (wp.good) begin
                mode   = MODE_WAYPOINT;
                reason = RSN_WP_RECOVERED;
              end else if (vis.good) begin
                mode   = MODE_VISION;
                reason = RSN_VISION_RECOVERED;
              end else if (wp.bad && vis.bad) begin
                reason = RSN_BOTH_LOST;
              end
            end
            default: ;  // held emergency stop stays
          endcase
          // drop a following mode whose source is not good
          if (mode == MODE_WAYPOINT && !wp.good) begin
            mode = vis.good ? MODE_VISION : MODE_STOP;
          end else if (mode == MODE_VISION && !vis.good) begin
            mode = wp.good ? MODE_WAYPOINT : MODE_STOP;
          end
        end
      end
    endcase

    dec.mode   = mode;
    dec.reason = reason;
  end

endmodule

>>> sv/gms_out_buf.sv
// Output register with one skid entry, so input ready has no combinational path from out_tready.
// Depends on gms_pkg.
module gms_out_buf import gms_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    can_push,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data,
  output logic    skid_valid
);

  logic    out_v_r, out_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t out_d_r, out_d_nxt;
  result_t skid_d_r, skid_d_nxt;
  logic    take;

  assign take = out_v_r && out_ready;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_d_nxt  = out_d_r;
    skid_d_nxt = skid_d_r;
    if (take) begin
      if (skid_v_r) begin
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else if (push) begin
        out_d_nxt = push_data;
      end else begin
        out_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (out_v_r) begin
        skid_d_nxt = push_data;
        skid_v_nxt = 1'b1;
      end else begin
        out_d_nxt = push_data;
        out_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign can_push   = !skid_v_r;
  assign out_valid  = out_v_r;
  assign out_data   = out_d_r;
  assign skid_valid = skid_v_r;

endmodule

>>> sv/guidance_mode_selector.sv
// Top level of the guidance mode selector: config registers, held mode, output buffer.
// Depends on gms_pkg, gms_source_track, gms_mode_decide, gms_out_buf and the assert header.
//
//   channel  direction  word / fields (low bit first)
//   in_      slave      leader_status, waypoint_valid, waypoint_age, vision_valid, vision_age
//   out_     master     guidance_mode, reason_code
//   cfg_     write      register index, data
//
// One tick per cycle while in_tready is high: the decision is one pass of compare-and-count
// logic from the accepted word to the output register or skid entry, where the result is registered.
// Reset clears the held mode, counters, latch and start flag and loads register defaults.
// A stalled result sits in the output register; one more tick goes to the skid entry,
// and in_tready drops only while that entry is full.
`include "guidance_mode_selector_assert.svh"

module guidance_mode_selector import gms_pkg::*; #(
  parameter int COUNT_CAP = COUNT_CAP_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // [1:0] leader_status, [2] waypoint_valid, [18:3] waypoint_age,
  // [19] vision_valid, [35:20] vision_age, [39:36] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [1:0] guidance_mode, [5:2] reason_code, [7:6] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [TIMEOUT_W-1:0] wp_timeout_r, vis_timeout_r;
  logic [THRESH_W-1:0]  wp_good_thr_r, wp_lost_thr_r;
  logic [THRESH_W-1:0]  vis_good_thr_r, vis_lost_thr_r;
  logic                 latch_en_r;

  mode_t       mode_r;
  logic        started_r;
  logic        latched_r;
  logic        in_accept;
  logic        skid_valid;
  src_status_t wp_status, vis_status;
  decision_t   dec;
  result_t     res, out_res;

  logic [1:0]       leader_status;
  logic             waypoint_valid, vision_valid;
  logic [AGE_W-1:0] waypoint_age, vision_age;

  assign leader_status  = in_tdata[1:0];
  assign waypoint_valid = in_tdata[2];
  assign waypoint_age   = in_tdata[18:3];
  assign vision_valid   = in_tdata[19];
  assign vision_age     = in_tdata[35:20];

  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_timeout_r   <= WP_TIMEOUT_RST;
      vis_timeout_r  <= VIS_TIMEOUT_RST;
      wp_good_thr_r  <= WP_GOOD_RST;
      wp_lost_thr_r  <= WP_LOST_RST;
      vis_good_thr_r <= VIS_GOOD_RST;
      vis_lost_thr_r <= VIS_LOST_RST;
      latch_en_r     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_WP_TIMEOUT:  wp_timeout_r   <= cfg_wdata;
        CFG_VIS_TIMEOUT: vis_timeout_r  <= cfg_wdata;
        CFG_WP_GOOD:     wp_good_thr_r  <= cfg_wdata[THRESH_W-1:0];
        CFG_WP_LOST:     wp_lost_thr_r  <= cfg_wdata[THRESH_W-1:0];
        CFG_VIS_GOOD:    vis_good_thr_r <= cfg_wdata[THRESH_W-1:0];
        CFG_VIS_LOST:    vis_lost_thr_r <= cfg_wdata[THRESH_W-1:0];
        CFG_LATCH_EN:    latch_en_r     <= cfg_wdata[0];
        default: ;  // ignore unknown index
      endcase
    end
  end

  gms_source_track #(.COUNT_CAP(COUNT_CAP)) u_wp_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (in_accept && dec.count_en),
    .src_valid (waypoint_valid),
    .src_age   (waypoint_age),
    .timeout   (wp_timeout_r),
    .good_thr  (wp_good_thr_r),
    .lost_thr  (wp_lost_thr_r),
    .status    (wp_status)
  );

  gms_source_track #(.COUNT_CAP(COUNT_CAP)) u_vis_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (in_accept && dec.count_en),
    .src_valid (vision_valid),
    .src_age   (vision_age),
    .timeout   (vis_timeout_r),
    .good_thr  (vis_good_thr_r),
    .lost_thr  (vis_lost_thr_r),
    .status    (vis_status)
  );

  gms_mode_decide u_decide (
    .mode_r        (mode_r),
    .started_r     (started_r),
    .latched_r     (latched_r),
    .latch_en      (latch_en_r),
    .leader_status (leader_status),
    .wp            (wp_status),
    .vis           (vis_status),
    .dec           (dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_STOP;
      started_r <= 1'b0;
      latched_r <= 1'b0;
    end else if (in_accept) begin
      mode_r    <= dec.mode;
      started_r <= 1'b1;
      latched_r <= latched_r || dec.latch_set;
    end
  end

  assign res.mode   = dec.mode;
  assign res.reason = dec.reason;

  gms_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_accept),
    .push_data  (res),
    .can_push   (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res),
    .skid_valid (skid_valid)
  );

  assign out_tdata = {2'b00, out_res};

  // skid entry fills only behind a waiting output word
  `GMS_ASSERT_NOW(a_skid_behind_out, skid_valid, out_tvalid)
  // latch never clears outside reset
  `GMS_ASSERT_NEXT(a_latch_holds, latched_r, latched_r)
  // latched estop wins over every tick except a leader fault
  `GMS_ASSERT_NEXT(a_latched_estop,
    latched_r && in_accept && leader_status != LDR_FAULT, mode_r == MODE_EMERG)
  // a fault tick always lands in stop and sets the start flag
  `GMS_ASSERT_NEXT(a_fault_stop, in_accept && leader_status == LDR_FAULT,
    mode_r == MODE_STOP && started_r)

endmodule
